[rtl/http_request_tokenizer_defines.svh]
// Assertion macros for the HTTP request tokenizer.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef HTTP_REQUEST_TOKENIZER_DEFINES_SVH
`define HTTP_REQUEST_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define HTOK_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled in reset
`define HTOK_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[rtl/htok_pkg.sv]
// Types, codes and per-byte step functions of the HTTP request tokenizer.
// No dependencies; used by every RTL module of the block.
`timescale 1ns / 1ps
`default_nettype none

package htok_pkg;

	// Parse phases
	typedef enum logic [2:0] {
		PH_METHOD  = 3'd0,
		PH_URL     = 3'd1,
		PH_VERSION = 3'd2,
		PH_KEY     = 3'd3,
		PH_VALUE   = 3'd4
	} phase_t;

	// Token kinds
	localparam logic [2:0] KIND_METHOD  = 3'd0;
	localparam logic [2:0] KIND_URL     = 3'd1;
	localparam logic [2:0] KIND_VERSION = 3'd2;
	localparam logic [2:0] KIND_KEY     = 3'd3;
	localparam logic [2:0] KIND_VALUE   = 3'd4;
	localparam logic [2:0] KIND_EVENT   = 3'd5;

	// Line events
	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_ACCEPTED  = 3'd1;
	localparam logic [2:0] EV_DROPPED   = 3'd2;
	localparam logic [2:0] EV_DONE      = 3'd3;
	localparam logic [2:0] EV_MALFORMED = 3'd4;

	// Escape stages
	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_PCT  = 2'd1;
	localparam logic [1:0] ESC_HEX1 = 2'd2;

	// Characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam int MaxRes = 4;

	typedef struct packed {
		phase_t     phase;
		logic       cr_pending;
		logic       colon_pending;
		logic [1:0] esc_stage;
		logic [7:0] esc_char;
		logic       key_seen;
		logic       value_seen;
		logic       line_has_bytes;
		logic       hold_valid;
		logic [7:0] hold_byte;
		logic [2:0] hold_kind;
	} st_t;

	typedef struct packed {
		logic [2:0] token_kind;
		logic [7:0] data_byte;
		logic       token_end;
		logic [2:0] line_event;
		logic       last_of_run;
	} res_t;

	// Results of one byte, slot 0 first
	typedef struct packed {
		res_t [MaxRes-1:0] res;
		logic [2:0]        n;
	} batch_t;

	typedef struct packed {
		st_t    st;
		batch_t b;
	} ctx_t;

	function automatic ctx_t emit(ctx_t c, logic [2:0] kind, logic [7:0] data,
		logic tend, logic [2:0] ev);
		ctx_t r;
		r = c;
		if (r.b.n < 3'(MaxRes)) begin
			r.b.res[r.b.n[1:0]] = '{token_kind: kind, data_byte: data, token_end: tend,
				line_event: ev, last_of_run: 1'b0};
			r.b.n = r.b.n + 3'd1;
		end
		return r;
	endfunction

	// Release the held byte and hold the new one
	function automatic ctx_t push(ctx_t c, logic [2:0] kind, logic [7:0] data);
		ctx_t r;
		r = c;
		if (r.st.hold_valid) r = emit(r, r.st.hold_kind, r.st.hold_byte, 1'b0, EV_NONE);
		r.st.hold_valid = 1'b1;
		r.st.hold_byte  = data;
		r.st.hold_kind  = kind;
		return r;
	endfunction

	function automatic ctx_t close_token(ctx_t c);
		ctx_t r;
		r = c;
		if (r.st.hold_valid) r = emit(r, r.st.hold_kind, r.st.hold_byte, 1'b1, EV_NONE);
		r.st.hold_valid = 1'b0;
		return r;
	endfunction

	function automatic logic is_hex(logic [7:0] ch);
		return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h66) ||
			(ch >= 8'h41 && ch <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(logic [7:0] ch);
		logic [7:0] v;
		v = 8'h00;
		if (ch >= 8'h30 && ch <= 8'h39) v = ch - 8'h30;
		else if (ch >= 8'h61 && ch <= 8'h66) v = ch - 8'h57;
		else if (ch >= 8'h41 && ch <= 8'h46) v = ch - 8'h37;
		return v[3:0];
	endfunction

	// Pass a broken escape through literally
	function automatic ctx_t flush_escape(ctx_t c);
		ctx_t r;
		r = c;
		if (r.st.esc_stage == ESC_PCT) begin
			r = push(r, KIND_URL, CH_PCT);
		end else if (r.st.esc_stage == ESC_HEX1) begin
			r = push(r, KIND_URL, CH_PCT);
			r = push(r, KIND_URL, r.st.esc_char);
		end
		r.st.esc_stage = ESC_NONE;
		return r;
	endfunction

	function automatic ctx_t resolve_holds(ctx_t c);
		ctx_t r;
		r = c;
		if (r.st.phase == PH_URL) r = flush_escape(r);
		if (r.st.phase == PH_KEY && r.st.colon_pending) begin
			r = push(r, KIND_KEY, CH_COLON);
			r.st.key_seen = 1'b1;
		end
		r.st.colon_pending = 1'b0;
		return r;
	endfunction

	function automatic ctx_t url_byte(ctx_t c, logic [7:0] ch, logic dec_en);
		ctx_t r;
		logic taken;
		r = c;
		taken = 1'b0;
		if (r.st.esc_stage == ESC_PCT) begin
			if (is_hex(ch)) begin
				r.st.esc_char  = ch;
				r.st.esc_stage = ESC_HEX1;
				taken = 1'b1;
			end else begin
				r = flush_escape(r);
			end
		end else if (r.st.esc_stage == ESC_HEX1) begin
			if (is_hex(ch)) begin
				r = push(r, KIND_URL, {hex_val(r.st.esc_char), hex_val(ch)});
				r.st.esc_stage = ESC_NONE;
				taken = 1'b1;
			end else begin
				r = flush_escape(r);
			end
		end
		if (!taken) begin
			if (ch == CH_SP) begin
				r = close_token(r);
				r.st.phase = PH_VERSION;
			end else if (ch == CH_PCT && dec_en) begin
				r.st.esc_stage = ESC_PCT;
			end else begin
				r = push(r, KIND_URL, ch);
			end
		end
		return r;
	endfunction

	function automatic ctx_t content(ctx_t c, logic [7:0] ch, logic dec_en);
		ctx_t r;
		logic taken;
		r = c;
		taken = 1'b0;
		r.st.line_has_bytes = 1'b1;
		unique case (r.st.phase)
			PH_METHOD: begin
				if (ch == CH_SP) begin
					r = close_token(r);
					r.st.phase = PH_URL;
				end else begin
					r = push(r, KIND_METHOD, ch);
				end
			end
			PH_URL: begin
				r = url_byte(r, ch, dec_en);
			end
			PH_VERSION: begin
				r = push(r, KIND_VERSION, ch);
			end
			PH_KEY: begin
				// a held colon either opens the value or is a key byte
				if (r.st.colon_pending) begin
					r.st.colon_pending = 1'b0;
					if (ch == CH_SP) begin
						r = close_token(r);
						r.st.phase = PH_VALUE;
						taken = 1'b1;
					end else begin
						r = push(r, KIND_KEY, CH_COLON);
						r.st.key_seen = 1'b1;
					end
				end
				if (!taken) begin
					if (ch == CH_COLON) begin
						r.st.colon_pending = 1'b1;
					end else begin
						r = push(r, KIND_KEY, ch);
						r.st.key_seen = 1'b1;
					end
				end
			end
			default: begin
				r = push(r, KIND_VALUE, ch);
				r.st.value_seen = 1'b1;
			end
		endcase
		return r;
	endfunction

	function automatic ctx_t line_end(ctx_t c);
		ctx_t r;
		r = resolve_holds(c);
		unique case (r.st.phase)
			PH_METHOD: begin
				if (r.st.line_has_bytes) begin
					r = close_token(r);
					r = emit(r, KIND_EVENT, 8'h00, 1'b0, EV_MALFORMED);
				end
			end
			PH_URL: begin
				r = close_token(r);
				r = emit(r, KIND_EVENT, 8'h00, 1'b0, EV_MALFORMED);
				r.st.phase = PH_METHOD;
			end
			PH_VERSION: begin
				r = close_token(r);
				r.st.phase = PH_KEY;
			end
			PH_KEY: begin
				if (!r.st.line_has_bytes) begin
					r = emit(r, KIND_EVENT, 8'h00, 1'b0, EV_DONE);
					r.st.phase = PH_METHOD;
				end else begin
					r = close_token(r);
					r = emit(r, KIND_EVENT, 8'h00, 1'b0, EV_DROPPED);
				end
			end
			default: begin
				r = close_token(r);
				r = emit(r, KIND_EVENT, 8'h00, 1'b0,
					(r.st.key_seen && r.st.value_seen) ? EV_ACCEPTED : EV_DROPPED);
				r.st.phase = PH_KEY;
			end
		endcase
		r.st.hold_valid     = 1'b0;
		r.st.line_has_bytes = 1'b0;
		r.st.key_seen       = 1'b0;
		r.st.value_seen     = 1'b0;
		r.st.colon_pending  = 1'b0;
		r.st.esc_stage      = ESC_NONE;
		return r;
	endfunction

	// Full work for one input byte
	function automatic ctx_t step_byte(st_t s, logic [7:0] ch, logic dec_en);
		ctx_t r;
		logic done;
		r.st = s;
		r.b  = '0;
		done = 1'b0;
		if (r.st.cr_pending) begin
			r.st.cr_pending = 1'b0;
			if (ch == CH_LF) begin
				r = line_end(r);
				done = 1'b1;
			end else begin
				r = content(r, CH_CR, dec_en);
			end
		end
		if (!done) begin
			if (ch == CH_CR) begin
				r = resolve_holds(r);
				r.st.cr_pending = 1'b1;
			end else begin
				r = content(r, ch, dec_en);
			end
		end
		if (r.b.n != 3'd0) r.b.res[2'(r.b.n - 3'd1)].last_of_run = 1'b1;
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/htok_step.sv]
// Parser state register and the single-pass per-byte step logic.
// Depends on htok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htok_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          byte_s1,
	input  logic                url_en,
	output htok_pkg::batch_t    batch
);

	htok_pkg::st_t  st_q;
	htok_pkg::ctx_t nxt;

	// Compute results and next state for the registered byte
	always_comb begin
		nxt   = htok_pkg::step_byte(st_q, byte_s1, url_en);
		batch = nxt.b;
	end

	// Advance parser state once per consumed byte; all-zero state is the method phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= nxt.st;
		end
	end

endmodule

`default_nettype wire

[rtl/htok_obuf.sv]
// Result buffer: holds the words of one byte and shifts them out one a cycle while out_ready is high.
// Depends on htok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htok_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  htok_pkg::batch_t batch,
	output logic             can_load,
	output logic             out_valid,
	input  logic             out_ready,
	output htok_pkg::res_t   head
);

	htok_pkg::res_t [htok_pkg::MaxRes-1:0] slot_q;
	logic [2:0]                            cnt_q;

	// Take a new batch once the last waiting word leaves
	assign out_valid = (cnt_q != 3'd0);
	assign can_load  = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_ready);
	assign head      = slot_q[0];

	// Hold the count of waiting words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= batch.n;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// Load or shift the payload slots
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= batch.res;
		end else if (out_valid && out_ready) begin
			for (int i = 0; i < htok_pkg::MaxRes - 1; i++) begin
				slot_q[i] <= slot_q[i+1];
			end
		end
	end

endmodule

`default_nettype wire

[rtl/http_request_tokenizer.sv]
// HTTP request tokenizer: takes one request byte per word and returns tagged token
// bytes and line events. A byte passes the input register, then one step of parse
// logic loads zero to four result words into the registered result buffer, which drives
// the output. One byte is taken every cycle as long as each byte yields at
// most one word and the output side is ready; a byte that yields n words holds the
// input side while the result buffer drains one word a cycle whenever out_ready is high.
// Write url_decode_enable through cfg_we/cfg_wdata only while the block is idle.
// Depends on htok_pkg, htok_step, htok_obuf and http_request_tokenizer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "http_request_tokenizer_defines.svh"

module http_request_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] token_kind,
	output logic [7:0] data_byte,
	output logic       token_end,
	output logic [2:0] line_event,
	output logic       last_of_run
);

	logic             url_en_q;
	logic             v_s1;
	logic [7:0]       byte_s1;
	logic             can_load;
	logic             advance;
	htok_pkg::batch_t batch;
	htok_pkg::res_t   head;

	// Hold the decode enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_en_q <= 1'b1;
		end else if (cfg_we) begin
			url_en_q <= cfg_wdata;
		end
	end

	// Consume the registered byte when the buffer can take its words
	assign advance  = v_s1 && can_load;
	assign in_ready = !v_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	htok_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.url_en  (url_en_q),
		.batch   (batch)
	);

	htok_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.batch     (batch),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	// Drive the result word
	assign token_kind  = head.token_kind;
	assign data_byte   = head.data_byte;
	assign token_end   = head.token_end;
	assign line_event  = head.line_event;
	assign last_of_run = head.last_of_run;

	// A stalled byte stays in the input register
	`HTOK_ASSERT_NEXT(a_s1_hold, v_s1 && !advance, v_s1 && $stable(byte_s1), "input byte lost while stalled")
	// Words produced by a byte show up at the output next cycle
	`HTOK_ASSERT_NEXT(a_res_shown, advance && batch.n != 3'd0, out_valid, "results not presented")
	// No byte produces more words than the buffer holds
	`HTOK_ASSERT_NOW(a_res_cap, advance, batch.n <= 3'd4, "result count above buffer depth")

endmodule

`default_nettype wire
